// ----- design/nbrf_pkg.sv -----
// nbrf_pkg: register indexes, reset values and field widths of the run finder
// used by nonblack_block_run_finder; no dependencies
package nbrf_pkg;

    localparam int WORD_W     = 32;
    localparam int ROW_W      = 10;
    localparam int POS_W      = 13;
    localparam int ADDR_W     = 22;
    localparam int LEN_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int WORD_BYTES = 4;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_PATTERN = 1'd1;

    localparam logic [POS_W-1:0]  ROW_LENGTH_RESET    = 13'd1280;
    localparam logic [WORD_W-1:0] BLACK_PATTERN_RESET = 32'd0;

    // run descriptor between the run tracker and the address stage
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [POS_W-1:0] row_len;
        logic [POS_W-1:0] start;
        logic [LEN_W-1:0] length;
    } run_desc_t;

endpackage

// ----- design/nonblack_block_run_finder.sv -----
// Streams one row as 32-bit pixel-pair words, accepting one word in every cycle
// while the result side keeps up. Words are compared against the black pattern
// and grouped into blocks of BLOCK_BYTES bytes; a run of non-black blocks yields
// one descriptor (frame address, length in bytes) when it closes, at the first
// black block or at the row end. A descriptor is registered behind the run
// tracker, then again in the address stage that forms row * row_length + start
// with a single 10 x 13 multiply.
// Depends on nbrf_pkg.
module nonblack_block_run_finder
    import nbrf_pkg::*;
#(
    parameter int BLOCK_BYTES   = 128,
    parameter int MAX_ROW_BYTES = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [WORD_W-1:0]     s_pixel_word,
    input  logic [ROW_W-1:0]      s_row_index,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ADDR_W-1:0]     m_run_address,
    output logic [LEN_W-1:0]      m_run_length
);

    localparam int OFF_W   = $clog2(BLOCK_BYTES);
    localparam int CAP     = MAX_ROW_BYTES & ~3;
    localparam int CAP_W   = 17;
    localparam logic [CAP_W-1:0]   CAP_V   = CAP_W'(CAP);
    localparam logic [OFF_W:0]     BLOCK_V = (OFF_W+1)'(BLOCK_BYTES);
    localparam logic [OFF_W:0]     STEP_O  = (OFF_W+1)'(WORD_BYTES);
    localparam logic [POS_W:0]     STEP_P  = (POS_W+1)'(WORD_BYTES);
    localparam logic [POS_W:0]     BLOCK_P = (POS_W+1)'(BLOCK_BYTES);

    // configuration
    logic [POS_W-1:0]  row_length_reg;
    logic [WORD_W-1:0] black_pattern_reg;

    // run tracking state
    logic [POS_W-1:0]  byte_position_reg, byte_position_next;
    logic [OFF_W-1:0]  block_off_reg, block_off_next;
    logic [POS_W-1:0]  block_begin_reg, block_begin_next;
    logic              block_has_color_reg, block_has_color_next;
    logic              run_open_reg, run_open_next;
    logic [POS_W-1:0]  run_start_reg, run_start_next;

    // stage between tracker and address stage
    logic              desc_valid_reg;
    run_desc_t         desc_reg, desc_next;
    logic              desc_advance;

    logic              m_valid_reg;
    logic [ADDR_W-1:0] m_run_address_reg;
    logic [LEN_W-1:0]  m_run_length_reg;

    logic              accept;
    logic              emit;
    logic [POS_W-1:0]  eff_len;
    logic [POS_W-1:0]  len_masked;
    logic [POS_W:0]    next_pos;
    logic [OFF_W:0]    off_sum;
    logic              row_end;
    logic              block_end;
    logic              color;
    logic [ROW_W+POS_W-1:0] product;

    // effective row length: multiple of four, clamped to 4 .. cap
    always_comb begin
        len_masked = row_length_reg & 13'h1FFC;
        eff_len    = len_masked;
        if (len_masked < POS_W'(WORD_BYTES)) begin
            eff_len = POS_W'(WORD_BYTES);
        end
        if ({{(CAP_W-POS_W){1'b0}}, eff_len} > CAP_V) begin
            eff_len = POS_W'(CAP);
        end
    end

    always_comb begin
        next_pos  = {1'b0, byte_position_reg} + STEP_P;
        off_sum   = {1'b0, block_off_reg} + STEP_O;
        row_end   = next_pos >= {1'b0, eff_len};
        block_end = row_end || (off_sum >= BLOCK_V);
        color     = block_has_color_reg || (s_pixel_word != black_pattern_reg);

        run_open_next        = run_open_reg;
        run_start_next       = run_start_reg;
        block_has_color_next = color;
        emit                 = 1'b0;
        desc_next.row        = s_row_index;
        desc_next.row_len    = eff_len;
        desc_next.start      = run_start_reg;
        desc_next.length     = '0;

        if (block_end) begin
            if (color) begin
                if (!run_open_reg) begin
                    run_open_next  = 1'b1;
                    run_start_next = block_begin_reg;
                end
            end else if (run_open_reg) begin
                emit             = 1'b1;
                desc_next.length = LEN_W'(block_begin_reg - run_start_reg);
                run_open_next    = 1'b0;
            end
            block_has_color_next = 1'b0;
        end

        if (row_end) begin
            if (run_open_next) begin
                emit             = 1'b1;
                desc_next.start  = run_start_next;
                desc_next.length = LEN_W'(next_pos - {1'b0, run_start_next});
                run_open_next    = 1'b0;
            end
            byte_position_next = '0;
            block_off_next     = '0;
            block_begin_next   = '0;
        end else begin
            byte_position_next = next_pos[POS_W-1:0];
            if (off_sum >= BLOCK_V) begin
                block_off_next   = OFF_W'(off_sum - BLOCK_V);
                block_begin_next = POS_W'({1'b0, block_begin_reg} + BLOCK_P);
            end else begin
                block_off_next   = off_sum[OFF_W-1:0];
                block_begin_next = block_begin_reg;
            end
        end
    end

    // pipeline flow: output register parts the result side from the tracker
    assign desc_advance = !m_valid_reg || m_ready;
    assign s_ready      = !desc_valid_reg || desc_advance;
    assign accept       = s_valid && s_ready;
    assign product      = desc_reg.row * desc_reg.row_len;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg      <= ROW_LENGTH_RESET;
            black_pattern_reg   <= BLACK_PATTERN_RESET;
            byte_position_reg   <= '0;
            block_off_reg       <= '0;
            block_begin_reg     <= '0;
            block_has_color_reg <= 1'b0;
            run_open_reg        <= 1'b0;
            run_start_reg       <= '0;
            desc_valid_reg      <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ROW_LENGTH:    row_length_reg    <= cfg_wdata[POS_W-1:0];
                    REG_BLACK_PATTERN: black_pattern_reg <= cfg_wdata[WORD_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                byte_position_reg   <= byte_position_next;
                block_off_reg       <= block_off_next;
                block_begin_reg     <= block_begin_next;
                block_has_color_reg <= block_has_color_next;
                run_open_reg        <= run_open_next;
                run_start_reg       <= run_start_next;
            end
            if (accept) begin
                desc_valid_reg <= emit;
            end else if (desc_advance) begin
                desc_valid_reg <= 1'b0;
            end
            if (desc_advance) begin
                m_valid_reg <= desc_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            desc_reg <= desc_next;
        end
        if (desc_advance && desc_valid_reg) begin
            m_run_address_reg <= ADDR_W'(product + {{ROW_W{1'b0}}, desc_reg.start});
            m_run_length_reg  <= desc_reg.length;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_run_address = m_run_address_reg;
    assign m_run_length  = m_run_length_reg;

    // block offset and block start always describe the current byte position
    a_block_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (block_begin_reg + POS_W'(block_off_reg)) == byte_position_reg)
        else $error("block tracking out of step with byte position");

    a_off_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, block_off_reg} < BLOCK_V)
        else $error("block offset beyond block size");

    a_start_order: assert property (@(posedge aclk) disable iff (!aresetn)
        run_open_reg |-> (run_start_reg <= block_begin_reg))
        else $error("open run starts after current block");

    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_run_length_reg != '0))
        else $error("empty run descriptor");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(m_run_address_reg))
        else $error("stalled descriptor overwritten");

endmodule

// ----- dv/tb_nonblack_block_run_finder.sv -----
`timescale 1ns / 100ps
// tb_nonblack_block_run_finder: self-checking bench for the non-black block run finder,
// predicting run descriptors word by word and comparing them on the result channel
// depends on nbrf_pkg and nonblack_block_run_finder
module tb_nonblack_block_run_finder;
    import nbrf_pkg::*;

    localparam int BLK_BYTES     = 128;
    localparam int MAX_ROW       = 4096;
    localparam int DRAIN_CYCLES  = 6;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_WORDS  = 800;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
    } run_t;

    typedef enum {FILL_BLACK, FILL_SPARSE, FILL_NEAR, FILL_DENSE} fill_t;

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = REG_ROW_LENGTH;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [WORD_W-1:0]     s_pixel_word  = '0;
    logic [ROW_W-1:0]      s_row_index   = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [ADDR_W-1:0]     m_run_address;
    logic [LEN_W-1:0]      m_run_length;

    // predictor state and its copy of the registers
    logic [POS_W-1:0]  row_len_q   = ROW_LENGTH_RESET;
    logic [WORD_W-1:0] black_q     = BLACK_PATTERN_RESET;
    logic [POS_W-1:0]  byte_pos_q  = '0;
    bit                blk_color_q = 1'b0;
    bit                run_open_q  = 1'b0;
    logic [POS_W-1:0]  run_start_q = '0;

    run_t pending_runs[$];

    int unsigned mismatches     = 0;
    int unsigned words_accepted = 0;
    int unsigned idle_cycles    = 0;
    int          burst_left     = 8;
    int          big_rows_left  = 3;
    int          hold_off_len   = 0;
    bit          sender_steady  = 1'b0;

    nonblack_block_run_finder #(
        .BLOCK_BYTES   (BLK_BYTES),
        .MAX_ROW_BYTES (MAX_ROW)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_word  (s_pixel_word),
        .s_row_index   (s_row_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_run_address (m_run_address),
        .m_run_length  (m_run_length)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // row length as the block uses it: whole words, at least one, at most the cap
    function automatic int unsigned eff_row_len();
        int unsigned len;
        len = row_len_q & 13'h1FFC;
        if (len < 4)
            len = 4;
        if (len > (MAX_ROW & ~3))
            len = MAX_ROW & ~3;
        return len;
    endfunction

    // advances the run tracker by one word; emit is set when a run closes
    function automatic void track_word(input logic [WORD_W-1:0] word,
                                       input logic [ROW_W-1:0] row,
                                       output bit emit, output run_t run);
        int unsigned len, pos, nxt, blk_begin, start, length;
        bit row_end, blk_end;
        len       = eff_row_len();
        pos       = byte_pos_q;
        nxt       = pos + 4;
        blk_begin = (pos / BLK_BYTES) * BLK_BYTES;
        row_end   = nxt >= len;
        blk_end   = row_end || ((nxt / BLK_BYTES) != (pos / BLK_BYTES));
        emit      = 1'b0;
        start     = 0;
        length    = 0;

        if (word != black_q)
            blk_color_q = 1'b1;

        if (blk_end) begin
            if (blk_color_q) begin
                if (!run_open_q) begin
                    run_open_q  = 1'b1;
                    run_start_q = blk_begin;
                end
            end else if (run_open_q) begin
                emit       = 1'b1;
                start      = run_start_q;
                length     = blk_begin - run_start_q;
                run_open_q = 1'b0;
            end
            blk_color_q = 1'b0;
        end

        if (row_end) begin
            if (run_open_q) begin
                emit       = 1'b1;
                start      = run_start_q;
                length     = nxt - run_start_q;
                run_open_q = 1'b0;
            end
            byte_pos_q = '0;
        end else begin
            byte_pos_q = nxt[POS_W-1:0];
        end

        run.addr = ADDR_W'(row * len + start);
        run.len  = LEN_W'(length);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        if (idx == REG_ROW_LENGTH)
            row_len_q = data[POS_W-1:0];
        else
            black_q = data;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // offers one word and holds it until taken, then maybe idles between bursts
    task automatic send_word(input logic [WORD_W-1:0] word, input logic [ROW_W-1:0] row);
        bit   emit;
        run_t run;
        int   gap;
        s_valid      <= 1'b1;
        s_pixel_word <= word;
        s_row_index  <= row;
        do
            @(posedge aclk);
        while (!s_ready);
        words_accepted++;
        track_word(word, row, emit, run);
        if (emit)
            pending_runs.push_back(run);
        if (!sender_steady) begin
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 40);
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // sender goes quiet until every expected descriptor is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_runs.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [WORD_W-1:0] make_word(input fill_t fill);
        case (fill)
            FILL_BLACK:  return black_q;
            FILL_SPARSE: return ($urandom_range(0, 15) == 0) ? $urandom() : black_q;
            // one flipped bit is enough to give the block content
            FILL_NEAR:   return ($urandom_range(0, 7) == 0) ?
                                black_q ^ (32'd1 << $urandom_range(0, 31)) : black_q;
            default:     return $urandom();
        endcase
    endfunction

    task automatic send_row(input int unsigned n_words, input logic [ROW_W-1:0] row,
                            input bit jitter);
        fill_t fill;
        int    pick;
        fill = FILL_DENSE;
        for (int unsigned k = 0; k < n_words; k++) begin
            if (k % (BLK_BYTES / WORD_BYTES) == 0) begin
                pick = $urandom_range(0, 99);
                fill = (pick < 35) ? FILL_BLACK : (pick < 55) ? FILL_SPARSE :
                       (pick < 70) ? FILL_NEAR : FILL_DENSE;
            end
            // broken rows: the row number changes part way through
            if (jitter && $urandom_range(0, 40) == 0)
                row = ROW_W'($urandom_range(0, 1023));
            send_word(make_word(fill), row);
        end
    endtask

    // reset values: one content block then a black one at the default row length
    task automatic test_reset_defaults();
        send_word(32'h0000_0001, 10'd5);
        for (int k = 1; k < 64; k++)
            send_word(32'h0000_0000, 10'd5);
        wait_drained();
    endtask

    // row length shrunk below the current position, then extremes of word and row number
    task automatic test_short_rows();
        write_reg(REG_ROW_LENGTH, 32'd4);
        send_word(32'hFFFF_0000, 10'd1023);
        send_word(32'h0000_0000, 10'd1023);
        send_word(32'h8000_0000, 10'd0);
        wait_drained();
        write_reg(REG_BLACK_PATTERN, 32'hFFFF_FFFF);
        write_reg(REG_ROW_LENGTH, 32'd3);
        send_word(32'hFFFF_FFFF, 10'd1023);
        send_word(32'h0000_0000, 10'd1023);
        send_word(32'hFFFF_FFFE, 10'd0);
        send_word(32'h7FFF_FFFF, 10'd512);
        wait_drained();
        // ten rounds down to two words per row
        write_reg(REG_ROW_LENGTH, 32'd10);
        send_word(32'hFFFF_FFFF, 10'd341);
        send_word(32'h1234_5678, 10'd341);
        send_word(32'hFFFF_FFFF, 10'd682);
        send_word(32'hFFFF_FFFF, 10'd682);
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering words
    task automatic test_backpressure();
        write_reg(REG_BLACK_PATTERN, 32'h0000_0000);
        write_reg(REG_ROW_LENGTH, 32'd4);
        sender_steady = 1'b1;
        hold_off_len  = HOLD_CYCLES;
        for (int k = 0; k < 120; k++)
            send_word($urandom() | 32'h1, ROW_W'($urandom_range(0, 1023)));
        sender_steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_rows();
        int unsigned first_word, n_words, n_rows, n;
        logic [POS_W-1:0] len;
        first_word = words_accepted;
        while (words_accepted - first_word < RANDOM_WORDS) begin
            wait_drained();
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 19))
                    0: begin
                        if (big_rows_left > 0) begin
                            big_rows_left--;
                            case (big_rows_left)
                                2:       len = 13'd4096;
                                1:       len = POS_W'($urandom_range(4097, 8191));
                                default: len = POS_W'($urandom_range(1024, 4095));
                            endcase
                        end else begin
                            len = 13'd128;
                        end
                    end
                    1:       len = POS_W'($urandom_range(0, 3));
                    2:       len = 13'd4;
                    3:       len = 13'd128;
                    4:       len = 13'd132;
                    5:       len = 13'd256;
                    6:       len = POS_W'($urandom_range(641, 1023));
                    default: len = POS_W'($urandom_range(5, 640));
                endcase
                // upper data bits are junk the register must ignore
                write_reg(REG_ROW_LENGTH, {($urandom_range(0, 3) == 0) ? 19'($urandom()) : 19'd0,
                                           len});
            end
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 3))
                    0:       write_reg(REG_BLACK_PATTERN, 32'h0000_0000);
                    1:       write_reg(REG_BLACK_PATTERN, 32'hFFFF_FFFF);
                    default: write_reg(REG_BLACK_PATTERN, $urandom());
                endcase
            end
            n_words = eff_row_len() / WORD_BYTES;
            n_rows  = (n_words > 256) ? 1 : $urandom_range(1, 4);
            for (int unsigned r = 0; r < n_rows; r++) begin
                n = n_words;
                // sometimes the phase ends part way into a row
                if (r == n_rows - 1 && $urandom_range(0, 5) == 0)
                    n = $urandom_range(1, n_words);
                send_row(n, ROW_W'($urandom_range(0, 1023)), $urandom_range(0, 9) == 0);
            end
        end
        wait_drained();
    endtask

    // result side stall pattern, with a counted hold-off on request
    initial begin
        int unsigned mode, cyc;
        mode = 0;
        cyc  = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (hold_off_len > 0) begin
                m_ready <= 1'b0;
                repeat (hold_off_len) @(posedge aclk);
                hold_off_len = 0;
            end else begin
                if (cyc % 64 == 0)
                    mode = $urandom_range(0, 3);
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= (cyc % 4 != 3);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic note_mismatch(input string msg);
        if (mismatches < 10)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        run_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_runs.size() == 0) begin
                note_mismatch($sformatf("unexpected word addr=%0d len=%0d",
                                        m_run_address, m_run_length));
            end else begin
                want = pending_runs.pop_front();
                if (m_run_address !== want.addr || m_run_length !== want.len)
                    note_mismatch($sformatf("addr exp=%0d got=%0d, len exp=%0d got=%0d",
                                            want.addr, m_run_address, want.len,
                                            m_run_length));
            end
        end
    end

    // watchdog on cycles where neither channel moves a word
    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_short_rows();
        test_backpressure();
        test_random_rows();

        wait_drained();
        if (mismatches == 0 && pending_runs.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d descriptors missing", mismatches,
                     pending_runs.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
